FILE: src/rsmt_pkg.sv
package rsmt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam logic [7:0] UNDEF_CODE = 8'd255;
   localparam logic [8:0] END_MAX = 9'd511;
   localparam logic [8:0] FULL_MARK = 9'd255;
   localparam int LABEL_COUNT = 8;

   localparam logic CSR_NUM_RANGES = 1'b0;
   localparam logic CSR_RANGE_LABELS = 1'b1;

   typedef enum logic [2:0] {
      OP_LOAD     = 3'd0,
      OP_SET_SIZE = 3'd1,
      OP_MAP      = 3'd2,
      OP_UNMAP    = 3'd3,
      OP_INSERT   = 3'd4,
      OP_TEST     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BEYOND = 2'd1,
      STAT_REJECT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_INS_CHK,
      S_SH_RD,
      S_SH_WR,
      S_INS_FIN,
      S_ENDS,
      S_OUT
   } state_type;

endpackage

FILE: src/rsmt_ram.sv
module rsmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ranged_symbol_map_table_unit.sv
// One item is in flight at a time; each shifted code costs a reverse map read, a forward
// map read-modify-write and a reverse map write. Reset is synchronous; afterwards both maps
// are swept to 255, and no item is accepted until the sweep ends.
module ranged_symbol_map_table_unit #(
   parameter int MAX_RANGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_symbol,
   input  logic [7:0]  req_code,
   input  logic [2:0]  req_range_index,
   input  logic [7:0]  req_count,
   input  logic [3:0]  req_selection,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic        rsp_selected,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   import rsmt_pkg::*;

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   state_type  state_ff, state_in;
   logic [7:0] clr_ff, clr_in;
   op_type     op_ff, op_in;
   logic [7:0] sym_ff, sym_in;
   logic [2:0] ri_ff, ri_in;
   logic [3:0] sel_ff, sel_in;
   logic [8:0] pos_ff, pos_in;
   logic [7:0] i_ff, i_in;
   logic [7:0] orig_ff, orig_in;
   logic [IW-1:0] k_ff, k_in;
   logic [8:0] sum_ff, sum_in;
   logic [8:0] sizes_ff [MAX_RANGES];
   logic [8:0] sizes_in [MAX_RANGES];
   logic [8:0] ends_ff [MAX_RANGES];
   logic [8:0] ends_in [MAX_RANGES];
   logic [3:0] num_ranges_ff;
   logic [31:0] labels_ff;
   logic [7:0] res_value_ff, res_value_in;
   logic       res_sel_ff, res_sel_in;
   status_type res_status_ff, res_status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_value_ff;
   logic       rsp_selected_ff;
   status_type rsp_status_ff;

   logic       fwd_we, rev_we;
   logic [7:0] fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
   logic [7:0] rev_waddr, rev_wdata, rev_raddr, rev_rdata;

   logic       accept, out_load, set_ok, reject1, reject2, in_range, ends_last;
   logic [4:0] nr5, n5, ri5, r5, req_ri5, last5;
   logic [IW-1:0] ends_addr, size_addr;
   logic [8:0] ends_rd, size_rd, start, size_sum_sat;
   logic [9:0] size_sum;
   logic [3:0] lab [LABEL_COUNT];
   logic [3:0] lab_sel;

   rsmt_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_fwd (
      .clock   (clock),
      .wr_en   (fwd_we),
      .wr_addr (fwd_waddr),
      .wr_data (fwd_wdata),
      .rd_addr (fwd_raddr),
      .rd_data (fwd_rdata)
   );

   rsmt_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_rev (
      .clock   (clock),
      .wr_en   (rev_we),
      .wr_addr (rev_waddr),
      .wr_data (rev_wdata),
      .rd_addr (rev_raddr),
      .rd_data (rev_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign nr5 = {1'b0, num_ranges_ff};
   assign n5  = (nr5 == 5'd0) ? 5'd1 :
                ((nr5 > 5'(MAX_RANGES)) ? 5'(MAX_RANGES) : nr5);
   assign last5 = n5 - 5'd1;
   assign ri5 = {2'b00, ri_ff};
   assign req_ri5 = {2'b00, req_range_index};
   assign set_ok  = (req_ri5 < 5'(MAX_RANGES));

   // Ends never decrease, so the range holding a code is the count of ends at or below it.
   always_comb begin
      r5 = '0;
      for (int j = 0; j < MAX_RANGES; j++) begin
         if ((5'(j) < n5) && (ends_ff[j] <= {1'b0, sym_ff})) begin
            r5 = r5 + 5'd1;
         end
      end
   end

   assign in_range = (r5 < n5);

   always_comb begin
      for (int j = 0; j < LABEL_COUNT; j++) begin
         lab[j] = labels_ff[4*j +: 4];
      end
   end

   assign lab_sel = (r5 < 5'(LABEL_COUNT)) ? lab[r5[2:0]] : 4'd0;

   always_comb begin
      ends_addr = ri5[IW-1:0];
      size_addr = k_ff;
      case (state_ff)
         S_LOOK: begin
            ends_addr = (op_ff == OP_TEST) ? r5[IW-1:0] : ri5[IW-1:0];
            size_addr = r5[IW-1:0];
         end
         S_INS_CHK: ends_addr = last5[IW-1:0];
         S_INS_FIN: size_addr = ri5[IW-1:0];
         default: ;
      endcase
   end

   assign ends_rd = ends_ff[ends_addr];
   assign size_rd = sizes_ff[size_addr];
   assign start   = (ends_rd >= size_rd) ? (ends_rd - size_rd) : 9'd0;
   assign size_sum = {1'b0, sum_ff} + {1'b0, size_rd};
   assign size_sum_sat = (size_sum > {1'b0, END_MAX}) ? END_MAX : size_sum[8:0];
   assign ends_last = (k_ff == IW'(MAX_RANGES - 1));

   assign reject1 = !(ri5 < n5) || (fwd_rdata != UNDEF_CODE);
   assign reject2 = (ends_rd >= FULL_MARK) || (pos_ff > ends_rd);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == 8'hff) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_SET_SIZE: state_in = set_ok ? S_ENDS : S_OUT;
                  OP_MAP, OP_UNMAP, OP_INSERT, OP_TEST: state_in = S_LOOK;
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_LOOK: state_in = ((op_ff == OP_INSERT) && !reject1) ? S_INS_CHK : S_OUT;
         S_INS_CHK: begin
            if (reject2) begin
               state_in = S_OUT;
            end else if (ends_rd == pos_ff) begin
               state_in = S_INS_FIN;
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: state_in = S_SH_WR;
         S_SH_WR: state_in = ((i_ff - 8'd1) == pos_ff[7:0]) ? S_INS_FIN : S_SH_RD;
         S_INS_FIN: state_in = S_ENDS;
         S_ENDS: if (ends_last) state_in = S_OUT;
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      op_in = op_ff;
      sym_in = sym_ff;
      ri_in = ri_ff;
      sel_in = sel_ff;
      pos_in = pos_ff;
      i_in = i_ff;
      orig_in = orig_ff;
      k_in = k_ff;
      sum_in = sum_ff;
      sizes_in = sizes_ff;
      ends_in = ends_ff;
      res_value_in = res_value_ff;
      res_sel_in = res_sel_ff;
      res_status_in = res_status_ff;
      fwd_we = 1'b0;
      rev_we = 1'b0;
      fwd_waddr = sym_ff;
      fwd_wdata = UNDEF_CODE;
      rev_waddr = i_ff;
      rev_wdata = UNDEF_CODE;
      fwd_raddr = sym_ff;
      rev_raddr = sym_ff;
      case (state_ff)
         S_CLEAR: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            fwd_waddr = clr_ff;
            rev_waddr = clr_ff;
            clr_in = clr_ff + 8'd1;
         end
         S_IDLE: begin
            fwd_raddr = req_symbol;
            rev_raddr = req_symbol;
            if (accept) begin
               op_in = op_type'(req_operation);
               sym_in = req_symbol;
               ri_in = req_range_index;
               sel_in = req_selection;
               res_value_in = 8'd0;
               res_sel_in = 1'b0;
               res_status_in = STAT_OK;
               k_in = '0;
               sum_in = '0;
               case (op_type'(req_operation))
                  OP_LOAD: begin
                     fwd_we = 1'b1;
                     rev_we = 1'b1;
                     fwd_waddr = req_symbol;
                     fwd_wdata = req_code;
                     rev_waddr = req_code;
                     rev_wdata = req_symbol;
                     res_value_in = req_code;
                  end
                  OP_SET_SIZE: begin
                     if (set_ok) begin
                        sizes_in[req_ri5[IW-1:0]] = {1'b0, req_count};
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LOOK: begin
            case (op_ff)
               OP_MAP: res_value_in = fwd_rdata;
               OP_UNMAP: res_value_in = rev_rdata;
               OP_TEST: begin
                  if (in_range) begin
                     res_sel_in = (lab_sel == sel_ff) && ({1'b0, sym_ff} >= start);
                  end else begin
                     res_status_in = STAT_BEYOND;
                  end
               end
               OP_INSERT: begin
                  pos_in = ends_rd;
                  if (reject1) begin
                     res_value_in = UNDEF_CODE;
                     res_status_in = STAT_REJECT;
                  end
               end
               default: ;
            endcase
         end
         S_INS_CHK: begin
            i_in = ends_rd[7:0];
            rev_raddr = ends_rd[7:0] - 8'd1;
            if (reject2) begin
               res_value_in = UNDEF_CODE;
               res_status_in = STAT_REJECT;
            end
         end
         S_SH_RD: begin
            orig_in = rev_rdata;
            fwd_raddr = rev_rdata;
         end
         S_SH_WR: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            fwd_waddr = orig_ff;
            fwd_wdata = fwd_rdata + 8'd1;
            rev_waddr = i_ff;
            rev_wdata = orig_ff;
            i_in = i_ff - 8'd1;
            rev_raddr = i_ff - 8'd2;
         end
         S_INS_FIN: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            fwd_waddr = sym_ff;
            fwd_wdata = pos_ff[7:0];
            rev_waddr = pos_ff[7:0];
            rev_wdata = sym_ff;
            if (size_rd < END_MAX) begin
               sizes_in[ri5[IW-1:0]] = size_rd + 9'd1;
            end
            res_value_in = pos_ff[7:0];
         end
         S_ENDS: begin
            ends_in[k_ff] = size_sum_sat;
            sum_in = size_sum_sat;
            k_in = k_ff + IW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         num_ranges_ff <= 4'd1;
         labels_ff <= '0;
         for (int j = 0; j < MAX_RANGES; j++) begin
            sizes_ff[j] <= '0;
            ends_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         sizes_ff <= sizes_in;
         ends_ff <= ends_in;
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_RANGES: num_ranges_ff <= csr_data[3:0];
               CSR_RANGE_LABELS: labels_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      sym_ff <= sym_in;
      ri_ff <= ri_in;
      sel_ff <= sel_in;
      pos_ff <= pos_in;
      i_ff <= i_in;
      orig_ff <= orig_in;
      k_ff <= k_in;
      sum_ff <= sum_in;
      res_value_ff <= res_value_in;
      res_sel_ff <= res_sel_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_selected_ff <= res_sel_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_selected = rsp_selected_ff;
   assign rsp_status = rsp_status_ff;

endmodule
